// ===== hw/rtl/bptc_pkg.sv =====
package bptc_pkg;

	localparam int unsigned RAW_W     = 24;
	localparam int unsigned COEFF_W   = 16;
	localparam int unsigned TEMP_W    = 19;
	localparam int unsigned PRES_W    = 32;
	localparam int unsigned DT_W      = 25;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned OFF_W     = 42;
	localparam int unsigned SENS_W    = 40;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [COEFF_W-1:0]   coeff_t;
	typedef logic [RAW_W-1:0]     raw_t;

	localparam reg_idx_t REG_SENS          = reg_idx_t'(0);
	localparam reg_idx_t REG_OFFSET        = reg_idx_t'(1);
	localparam reg_idx_t REG_SENS_TEMP     = reg_idx_t'(2);
	localparam reg_idx_t REG_OFFSET_TEMP   = reg_idx_t'(3);
	localparam reg_idx_t REG_REF_TEMP      = reg_idx_t'(4);
	localparam reg_idx_t REG_TEMP_SENS     = reg_idx_t'(5);

	localparam logic signed [TEMP_W-1:0] TEMP_REF      = TEMP_W'(2000);
	localparam logic signed [TEMP_W-1:0] TEMP_COLD     = TEMP_W'(-1500);

	localparam logic signed [OFF_W-1:0]  K_OFF2_LOW    = OFF_W'(61);
	localparam logic signed [OFF_W-1:0]  K_OFF2_VLOW   = OFF_W'(15);
	localparam logic signed [SENS_W-1:0] K_SENS2_LOW   = SENS_W'(2);
	localparam logic signed [SENS_W-1:0] K_SENS2_VLOW  = SENS_W'(8);

	typedef struct packed {
		coeff_t c1;
		coeff_t c2;
		coeff_t c3;
		coeff_t c4;
	} back_coeffs_t;

	typedef struct packed {
		raw_t                     d1;
		logic signed [DT_W-1:0]   dt;
		logic signed [TEMP_W-1:0] temp1;
		logic                     is_low;
		logic                     is_very_low;
	} mid_entry_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PRES_W-1:0] pres;
	} out_entry_t;

endpackage

// ===== hw/rtl/bptc_fifo.sv =====
module bptc_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/bptc_front.sv =====
module bptc_front #(
	parameter int MID_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  bptc_pkg::raw_t        raw_pressure,
	input  bptc_pkg::raw_t        raw_temperature,
	input  bptc_pkg::coeff_t      ref_temp_coeff,
	input  bptc_pkg::coeff_t      temp_sens_coeff,
	input  logic                  mid_pop,
	output logic                  mid_push,
	output bptc_pkg::mid_entry_t  mid_data
);

	localparam int CNT_W  = $clog2(MID_DEPTH + 1);
	localparam int PROD_W = bptc_pkg::DT_W + bptc_pkg::COEFF_W + 1;
	localparam int TW     = bptc_pkg::TEMP_W;

	logic [CNT_W-1:0]                    credit_q;
	logic                                accept;
	logic signed [bptc_pkg::DT_W-1:0]    dt_c;
	logic                                vld_s1;
	logic                                vld_s2;
	bptc_pkg::raw_t                      d1_s1;
	bptc_pkg::raw_t                      d1_s2;
	logic signed [bptc_pkg::DT_W-1:0]    dt_s1;
	logic signed [bptc_pkg::DT_W-1:0]    dt_s2;
	logic signed [PROD_W-1:0]            prod_c;
	logic signed [PROD_W-1:0]            prod_s2;
	logic signed [TW-1:0]                temp1_c;

	assign full   = (credit_q == CNT_W'(MID_DEPTH));
	assign accept = push && !full;

	// credit covers the pipeline plus the queue entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !mid_pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (mid_pop && !accept) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp_coeff, 8'h00});
	assign prod_c = dt_s1 * $signed({1'b0, temp_sens_coeff});
	assign temp1_c = bptc_pkg::TEMP_REF + $signed(prod_s2[PROD_W-1:23]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		d1_s1   <= raw_pressure;
		dt_s1   <= dt_c;
		d1_s2   <= d1_s1;
		dt_s2   <= dt_s1;
		prod_s2 <= prod_c;
	end

	always_comb begin
		mid_push             = vld_s2;
		mid_data.d1          = d1_s2;
		mid_data.dt          = dt_s2;
		mid_data.temp1       = temp1_c;
		mid_data.is_low      = (temp1_c < bptc_pkg::TEMP_REF);
		mid_data.is_very_low = (temp1_c < bptc_pkg::TEMP_COLD);
	end

endmodule

// ===== hw/rtl/bptc_back.sv =====
module bptc_back #(
	parameter int OUT_DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   mid_empty,
	input  bptc_pkg::mid_entry_t                   mid_data,
	output logic                                   mid_pop,
	input  bptc_pkg::back_coeffs_t                 coeffs,
	input  logic                                   pop,
	output logic                                   empty,
	output logic signed [bptc_pkg::TEMP_W-1:0]     temperature_centi,
	output logic signed [bptc_pkg::PRES_W-1:0]     pressure_centi
);

	localparam int CNT_W   = $clog2(OUT_DEPTH + 1);
	localparam int TW      = bptc_pkg::TEMP_W;
	localparam int XW      = TW + 1;
	localparam int OW      = bptc_pkg::OFF_W;
	localparam int SW      = bptc_pkg::SENS_W;
	localparam int DW      = bptc_pkg::DT_W;
	localparam int MP_W    = DW + bptc_pkg::COEFF_W + 1;
	localparam int DT2_W   = 2 * DW;
	localparam int SQ_W    = 2 * XW;
	localparam int T2_W    = 18;
	localparam int SPLIT   = SW / 2;
	localparam int PPL_W   = bptc_pkg::RAW_W + SPLIT;
	localparam int PPH_W   = bptc_pkg::RAW_W + 1 + (SW - SPLIT);
	localparam int PROD_W  = 66;
	localparam int Q_W     = PROD_W - 21 + 1;
	localparam int OUT_W   = $bits(bptc_pkg::out_entry_t);

	logic [CNT_W-1:0] credit_q;
	logic             out_pop;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	bptc_pkg::mid_entry_t      e_s1;
	logic signed [MP_W-1:0]    off_prod_s2, sens_prod_s2;
	logic signed [DT2_W-1:0]   dt2_s2;
	logic signed [XW-1:0]      dlo_s2, dvl_s2;
	bptc_pkg::raw_t            d1_s2, d1_s3, d1_s4, d1_s5;
	logic signed [TW-1:0]      temp1_s2, temp1_s3;
	logic                      lo_s2, vlo_s2, lo_s3, vlo_s3;
	logic signed [OW-1:0]      off1_s3, off1_s4;
	logic signed [SW-1:0]      sens1_s3, sens1_s4;
	logic [T2_W-1:0]           t2_s3;
	logic signed [SQ_W-1:0]    dlo2_s3, dvl2_s3;
	logic signed [OW-1:0]      off2_c, off2_s4;
	logic signed [SW-1:0]      sens2_c, sens2_s4;
	logic signed [TW-1:0]      temp_c, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic signed [OW-1:0]      off_s5, off_s6, off_s7;
	logic signed [SW-1:0]      sens_s5;
	logic [PPL_W-1:0]          pp_lo_s6;
	logic signed [PPH_W-1:0]   pp_hi_s6;
	logic signed [PROD_W-1:0]  prod_s7;
	logic signed [Q_W-1:0]     q_s8;
	bptc_pkg::out_entry_t      out_wdata;
	logic [OUT_W-1:0]          out_rdata;
	bptc_pkg::out_entry_t      out_head;

	assign out_pop = pop && !empty;
	assign mid_pop = !mid_empty && (credit_q != CNT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (mid_pop && !out_pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_pop && !mid_pop) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= mid_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		temp_c  = temp1_s3;
		if (lo_s3) begin
			off2_c  = OW'($signed(dlo2_s3[SQ_W-1:4])) * bptc_pkg::K_OFF2_LOW;
			sens2_c = SW'(dlo2_s3) * bptc_pkg::K_SENS2_LOW;
			temp_c  = temp1_s3 - TW'($signed({1'b0, t2_s3}));
			if (vlo_s3) begin
				off2_c  = off2_c + OW'(dvl2_s3) * bptc_pkg::K_OFF2_VLOW;
				sens2_c = sens2_c + SW'(dvl2_s3) * bptc_pkg::K_SENS2_VLOW;
			end
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= mid_data;

		off_prod_s2  <= $signed(e_s1.dt) * $signed({1'b0, coeffs.c4});
		sens_prod_s2 <= $signed(e_s1.dt) * $signed({1'b0, coeffs.c3});
		dt2_s2       <= $signed(e_s1.dt) * $signed(e_s1.dt);
		dlo_s2       <= XW'($signed(e_s1.temp1)) - XW'(bptc_pkg::TEMP_REF);
		dvl_s2       <= XW'($signed(e_s1.temp1)) - XW'(bptc_pkg::TEMP_COLD);
		d1_s2        <= e_s1.d1;
		temp1_s2     <= e_s1.temp1;
		lo_s2        <= e_s1.is_low;
		vlo_s2       <= e_s1.is_very_low;

		off1_s3  <= OW'($signed({1'b0, coeffs.c2, 17'b0}))
			+ OW'($signed(off_prod_s2[MP_W-1:6]));
		sens1_s3 <= SW'($signed({1'b0, coeffs.c1, 16'b0}))
			+ SW'($signed(sens_prod_s2[MP_W-1:7]));
		t2_s3    <= dt2_s2[T2_W+30:31];
		dlo2_s3  <= dlo_s2 * dlo_s2;
		dvl2_s3  <= dvl_s2 * dvl_s2;
		d1_s3    <= d1_s2;
		temp1_s3 <= temp1_s2;
		lo_s3    <= lo_s2;
		vlo_s3   <= vlo_s2;

		off1_s4  <= off1_s3;
		sens1_s4 <= sens1_s3;
		off2_s4  <= off2_c;
		sens2_s4 <= sens2_c;
		temp_s4  <= temp_c;
		d1_s4    <= d1_s3;

		off_s5  <= off1_s4 - off2_s4;
		sens_s5 <= sens1_s4 - sens2_s4;
		temp_s5 <= temp_s4;
		d1_s5   <= d1_s4;

		// split product of raw pressure and sensitivity
		pp_lo_s6 <= {{SPLIT{1'b0}}, d1_s5} * {{bptc_pkg::RAW_W{1'b0}}, sens_s5[SPLIT-1:0]};
		pp_hi_s6 <= $signed({1'b0, d1_s5}) * $signed(sens_s5[SW-1:SPLIT]);
		off_s6   <= off_s5;
		temp_s6  <= temp_s5;

		prod_s7 <= (PROD_W'(pp_hi_s6) <<< SPLIT) + PROD_W'($signed({1'b0, pp_lo_s6}));
		off_s7  <= off_s6;
		temp_s7 <= temp_s6;

		q_s8    <= Q_W'($signed(prod_s7[PROD_W-1:21])) - Q_W'(off_s7);
		temp_s8 <= temp_s7;
	end

	// q >> 15 spans 31 bits, always inside the int32 range
	assign out_wdata.temp = temp_s8;
	assign out_wdata.pres = bptc_pkg::PRES_W'($signed(q_s8[Q_W-1:15]));

	bptc_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH (OUT_W)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (vld_s8),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign out_head          = out_rdata;
	assign temperature_centi = out_head.temp;
	assign pressure_centi    = out_head.pres;

endmodule

// ===== hw/rtl/baro_pressure_temp_compensation.sv =====
// Throughput: one reading pair per cycle when pop keeps up.
// full rises once MID_DEPTH pairs sit in the front pipe and the middle queue.
// Async reset clears queues, pipeline valids and all six coefficients to zero.
module baro_pressure_temp_compensation #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [bptc_pkg::RAW_W-1:0]          raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]          raw_temperature,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centi,
	output logic signed [bptc_pkg::PRES_W-1:0]  pressure_centi,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bptc_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [bptc_pkg::COEFF_W-1:0]        cfg_data
);

	localparam int MID_W = $bits(bptc_pkg::mid_entry_t);

	bptc_pkg::coeff_t       sens_coeff_q;
	bptc_pkg::coeff_t       offset_coeff_q;
	bptc_pkg::coeff_t       sens_temp_coeff_q;
	bptc_pkg::coeff_t       offset_temp_coeff_q;
	bptc_pkg::coeff_t       ref_temp_coeff_q;
	bptc_pkg::coeff_t       temp_sens_coeff_q;
	bptc_pkg::back_coeffs_t back_coeffs;
	bptc_pkg::mid_entry_t   mid_wdata;
	bptc_pkg::mid_entry_t   mid_head;
	logic [MID_W-1:0]       mid_rdata;
	logic                   mid_push;
	logic                   mid_pop;
	logic                   mid_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_coeff_q        <= '0;
			offset_coeff_q      <= '0;
			sens_temp_coeff_q   <= '0;
			offset_temp_coeff_q <= '0;
			ref_temp_coeff_q    <= '0;
			temp_sens_coeff_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bptc_pkg::REG_SENS:        sens_coeff_q        <= cfg_data;
				bptc_pkg::REG_OFFSET:      offset_coeff_q      <= cfg_data;
				bptc_pkg::REG_SENS_TEMP:   sens_temp_coeff_q   <= cfg_data;
				bptc_pkg::REG_OFFSET_TEMP: offset_temp_coeff_q <= cfg_data;
				bptc_pkg::REG_REF_TEMP:    ref_temp_coeff_q    <= cfg_data;
				bptc_pkg::REG_TEMP_SENS:   temp_sens_coeff_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign back_coeffs.c1 = sens_coeff_q;
	assign back_coeffs.c2 = offset_coeff_q;
	assign back_coeffs.c3 = sens_temp_coeff_q;
	assign back_coeffs.c4 = offset_temp_coeff_q;

	bptc_front #(
		.MID_DEPTH (MID_DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.ref_temp_coeff  (ref_temp_coeff_q),
		.temp_sens_coeff (temp_sens_coeff_q),
		.mid_pop         (mid_pop),
		.mid_push        (mid_push),
		.mid_data        (mid_wdata)
	);

	bptc_fifo #(
		.DEPTH (MID_DEPTH),
		.WIDTH (MID_W)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_head = mid_rdata;

	bptc_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.mid_empty         (mid_empty),
		.mid_data          (mid_head),
		.mid_pop           (mid_pop),
		.coeffs            (back_coeffs),
		.pop               (pop),
		.empty             (empty),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi)
	);

endmodule

// ===== hw/rtl/bptc_chk.sv =====
module bptc_chk (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic pop,
	input logic empty,
	input logic cfg_valid,
	input logic cfg_ready
);

	logic [5:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != '0)
		else $error("result offered with no transaction outstanding");

	a_not_full_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 |-> !full)
		else $error("full while nothing outstanding");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pend_q == '0 |-> ##12 !empty)
		else $error("result late on an idle block");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind baro_pressure_temp_compensation bptc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.pop       (pop),
	.empty     (empty),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// ===== test/tb_baro_pressure_temp_compensation.sv =====
module tb_baro_pressure_temp_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int               CYCLE_LIMIT  = 200000;
	localparam int               DRAIN_CYCLES = 16;
	localparam bptc_pkg::raw_t   RAW_MAX      = '1;
	localparam bptc_pkg::coeff_t COEFF_MAX    = '1;
	localparam longint           SCALE_T      = 64'sd8388608;
	localparam longint           PRES_MAX     = 64'sd2147483647;
	localparam longint           PRES_MIN     = -64'sd2147483648;

	// indexes past the coefficient file; writes there must be dropped
	localparam bptc_pkg::reg_idx_t REG_SPARE_LO = bptc_pkg::reg_idx_t'(6);
	localparam bptc_pkg::reg_idx_t REG_SPARE_HI = bptc_pkg::reg_idx_t'(7);

	typedef struct packed {
		bptc_pkg::raw_t d1;
		bptc_pkg::raw_t d2;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	bptc_pkg::raw_t raw_pressure = '0;
	bptc_pkg::raw_t raw_temperature = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [bptc_pkg::TEMP_W-1:0] temperature_centi;
	logic signed [bptc_pkg::PRES_W-1:0] pressure_centi;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	bptc_pkg::reg_idx_t cfg_index = '0;
	bptc_pkg::coeff_t cfg_data = '0;

	bptc_pkg::coeff_t coeff_regs [0:5] = '{default: '0};
	reading_t pending_readings [$];
	bptc_pkg::out_entry_t expected_results [$];
	reading_t next_reading;
	bptc_pkg::out_entry_t oldest_result;

	logic hold = 1'b0;
	int send_idle = 33;
	int recv_idle = 63;
	int accepted = 0;
	int checked = 0;
	int errors = 0;
	int low_count = 0;
	int very_low_count = 0;
	int coeff_sets = 1;
	int reg_writes = 0;
	int cycles = 0;

	baro_pressure_temp_compensation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.empty(empty),
		.pop(pop),
		.temperature_centi(temperature_centi),
		.pressure_centi(pressure_centi),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bptc_pkg::out_entry_t compensate(bptc_pkg::raw_t d1,
			bptc_pkg::raw_t d2);
		longint dt, temp, off, sens, t2, dlo, off2, sens2, dvl, p;
		bptc_pkg::out_entry_t r;
		dt = longint'(d2) - longint'(coeff_regs[bptc_pkg::REG_REF_TEMP]) * 256;
		temp = bptc_pkg::TEMP_REF
			+ ((dt * longint'(coeff_regs[bptc_pkg::REG_TEMP_SENS])) >>> 23);
		off = longint'(coeff_regs[bptc_pkg::REG_OFFSET]) * 131072
			+ ((longint'(coeff_regs[bptc_pkg::REG_OFFSET_TEMP]) * dt) >>> 6);
		sens = longint'(coeff_regs[bptc_pkg::REG_SENS]) * 65536
			+ ((longint'(coeff_regs[bptc_pkg::REG_SENS_TEMP]) * dt) >>> 7);
		if (temp < bptc_pkg::TEMP_REF) begin
			low_count++;
			t2 = (dt * dt) >>> 31;
			dlo = temp - bptc_pkg::TEMP_REF;
			off2 = bptc_pkg::K_OFF2_LOW * ((dlo * dlo) >>> 4);
			sens2 = bptc_pkg::K_SENS2_LOW * (dlo * dlo);
			if (temp < bptc_pkg::TEMP_COLD) begin
				very_low_count++;
				dvl = temp - bptc_pkg::TEMP_COLD;
				off2 += bptc_pkg::K_OFF2_VLOW * (dvl * dvl);
				sens2 += bptc_pkg::K_SENS2_VLOW * (dvl * dvl);
			end
			temp -= t2;
			off -= off2;
			sens -= sens2;
		end
		p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
		if (p > PRES_MAX)
			p = PRES_MAX;
		if (p < PRES_MIN)
			p = PRES_MIN;
		r.temp = temp[bptc_pkg::TEMP_W-1:0];
		r.pres = p[bptc_pkg::PRES_W-1:0];
		return r;
	endfunction

	// raw temperature whose first-order result lands on the given hundredths, else a random one
	function automatic bptc_pkg::raw_t raw_temp_for(longint centi);
		longint k, dt, d2, c6;
		c6 = longint'(coeff_regs[bptc_pkg::REG_TEMP_SENS]);
		k = centi - bptc_pkg::TEMP_REF;
		if (c6 == 0)
			return bptc_pkg::raw_t'($urandom);
		if (k >= 0)
			dt = (k * SCALE_T + c6 - 1) / c6;
		else
			dt = -((-k * SCALE_T) / c6);
		d2 = longint'(coeff_regs[bptc_pkg::REG_REF_TEMP]) * 256 + dt;
		if (d2 < 0 || d2 > longint'(RAW_MAX))
			return bptc_pkg::raw_t'($urandom);
		return bptc_pkg::raw_t'(d2);
	endfunction

	function automatic reading_t random_reading();
		reading_t r;
		case ($urandom_range(15))
			0: r.d1 = '0;
			1: r.d1 = RAW_MAX;
			default: r.d1 = bptc_pkg::raw_t'($urandom);
		endcase
		case ($urandom_range(15))
			0: r.d2 = '0;
			1: r.d2 = RAW_MAX;
			2, 3, 4, 5: r.d2 = bptc_pkg::raw_t'($urandom);
			default: r.d2 = raw_temp_for(longint'($urandom_range(11000)) - 6000);
		endcase
		return r;
	endfunction

	task automatic add_reading(bptc_pkg::raw_t d1, bptc_pkg::raw_t d2);
		reading_t r;
		r.d1 = d1;
		r.d2 = d2;
		pending_readings.push_back(r);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			pending_readings.push_back(random_reading());
	endtask

	task automatic write_coeff(bptc_pkg::reg_idx_t idx, bptc_pkg::coeff_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= bptc_pkg::REG_TEMP_SENS)
			coeff_regs[idx] = val;
		reg_writes++;
	endtask

	task automatic set_coeffs(bptc_pkg::coeff_t c1, bptc_pkg::coeff_t c2,
			bptc_pkg::coeff_t c3, bptc_pkg::coeff_t c4,
			bptc_pkg::coeff_t c5, bptc_pkg::coeff_t c6);
		write_coeff(bptc_pkg::REG_SENS, c1);
		write_coeff(REG_SPARE_LO, bptc_pkg::coeff_t'($urandom));
		write_coeff(bptc_pkg::REG_OFFSET, c2);
		write_coeff(bptc_pkg::REG_SENS_TEMP, c3);
		write_coeff(bptc_pkg::REG_OFFSET_TEMP, c4);
		write_coeff(bptc_pkg::REG_REF_TEMP, c5);
		write_coeff(bptc_pkg::REG_TEMP_SENS, c6);
		write_coeff(REG_SPARE_HI, bptc_pkg::coeff_t'($urandom));
		cfg_valid <= 1'b0;
		coeff_sets++;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending_readings.size() != 0 || push ||
			expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				expected_results.push_back(compensate(raw_pressure, raw_temperature));
				accepted++;
			end
			if (!push || !full) begin
				if (!hold && pending_readings.size() != 0 &&
						$urandom_range(99) >= send_idle) begin
					next_reading = pending_readings.pop_front();
					push <= 1'b1;
					raw_pressure <= next_reading.d1;
					raw_temperature <= next_reading.d2;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, expected none, %s %0d pres %0d",
						$time, "got temp", temperature_centi, pressure_centi);
				end else begin
					oldest_result = expected_results.pop_front();
					checked++;
					if (temperature_centi !== oldest_result.temp) begin
						errors++;
						$display("%0t: temperature_centi expected %0d got %0d",
							$time, oldest_result.temp, temperature_centi);
					end
					if (pressure_centi !== oldest_result.pres) begin
						errors++;
						$display("%0t: pressure_centi expected %0d got %0d",
							$time, oldest_result.pres, pressure_centi);
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int hold_at;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unprogrammed coefficients
		add_reading('0, '0);
		add_reading(RAW_MAX, RAW_MAX);
		add_reading(RAW_MAX, '0);
		add_reading('0, RAW_MAX);
		add_random(100);
		wait_idle();

		// typical part, across the temperature bands
		set_coeffs(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
		add_reading(24'd6465444, raw_temp_for(2007));
		add_reading(RAW_MAX, raw_temp_for(2000));
		add_reading('0, raw_temp_for(1999));
		add_reading(bptc_pkg::raw_t'($urandom), raw_temp_for(0));
		add_reading(bptc_pkg::raw_t'($urandom), raw_temp_for(-1500));
		add_reading(bptc_pkg::raw_t'($urandom), raw_temp_for(-1501));
		add_reading(RAW_MAX, raw_temp_for(-4000));
		add_reading(RAW_MAX, '0);
		add_reading('0, RAW_MAX);
		add_reading(RAW_MAX, RAW_MAX);
		add_random(300);
		hold_at = accepted + 150;
		while (accepted < hold_at)
			@(posedge clk);
		hold <= 1'b1;
		do @(posedge clk); while (push || expected_results.size() != 0);
		hold <= 1'b0;
		wait_idle();

		send_idle <= 63;
		recv_idle <= 33;
		set_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
		add_reading(RAW_MAX, '0);
		add_reading(RAW_MAX, RAW_MAX);
		add_reading('0, '0);
		add_random(250);
		wait_idle();

		set_coeffs(bptc_pkg::coeff_t'($urandom), bptc_pkg::coeff_t'($urandom),
			bptc_pkg::coeff_t'($urandom), bptc_pkg::coeff_t'($urandom),
			bptc_pkg::coeff_t'($urandom), bptc_pkg::coeff_t'($urandom));
		add_random(350);
		wait_idle();

		send_idle <= 0;
		recv_idle <= 0;
		set_coeffs('0, '0, '0, '0, '0, '0);
		add_random(150);
		wait_idle();

		set_coeffs(bptc_pkg::coeff_t'($urandom), bptc_pkg::coeff_t'($urandom),
			bptc_pkg::coeff_t'($urandom), bptc_pkg::coeff_t'($urandom),
			bptc_pkg::coeff_t'($urandom), bptc_pkg::coeff_t'($urandom));
		add_random(500);
		wait_idle();

		$display("Checked %0d readings over %0d coefficient sets:", checked, coeff_sets);
		$display("%0d below 20 C, %0d below -15 C, %0d coefficient writes incl. spare indexes.",
			low_count, very_low_count, reg_writes);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
